FILE: rtl/core/dnd_pkg.sv
// ----------------------------------------------------------------------------
// dnd_pkg: shared types and constants for the day-number-to-date converter
// Field widths, calendar constants and reciprocals for constant division.
// ----------------------------------------------------------------------------
package dnd_pkg;

  // Port field widths
  localparam int unsigned DAY_NUM_W = 32;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DOM_W     = 5;

  // Internal widths
  localparam int unsigned Z_W      = 32;  // day count from 0000-03-01
  localparam int unsigned ERA_W    = 15;  // 400-year era index
  localparam int unsigned REM_W    = 19;  // remainder before correction, < 2 eras
  localparam int unsigned DOE_W    = 18;  // day of era, 0..146096
  localparam int unsigned YOE_W    = 9;   // year of era, 0..399
  localparam int unsigned DOY_W    = 9;   // day of March-based year, 0..365
  localparam int unsigned MP_W     = 4;   // March-based month, 0..11
  localparam int unsigned YEAR_F_W = 24;  // unclamped year
  localparam int unsigned MT_W     = 11;  // 5*doy+2 and 153*mp+2

  // Pipeline layout
  localparam int unsigned ERA_STAGES = 4;
  localparam int unsigned NUM_STAGES = 11;

  typedef logic [DAY_NUM_W-1:0] day_num_t;
  typedef logic [YEAR_W-1:0]    year_t;
  typedef logic [MONTH_W-1:0]   month_t;
  typedef logic [DOM_W-1:0]     dom_t;
  typedef logic [ERA_W-1:0]     era_t;
  typedef logic [DOE_W-1:0]     doe_t;

  // Calendar constants
  localparam logic [Z_W-1:0]      MARCH_OFFSET = 32'd305;
  localparam logic [DOE_W-1:0]    ERA_DAYS     = 18'd146097;
  localparam logic [DOE_W-1:0]    ERA_LAST_DAY = 18'd146096;
  localparam logic [DOE_W-1:0]    CENT_DAYS_1  = 18'd36524;
  localparam logic [DOE_W-1:0]    CENT_DAYS_2  = 18'd73048;
  localparam logic [DOE_W-1:0]    CENT_DAYS_3  = 18'd109572;
  localparam logic [YOE_W-1:0]    YEAR_DAYS    = 9'd365;
  localparam logic [YOE_W-1:0]    ERA_YEARS    = 9'd400;
  localparam logic [YOE_W-1:0]    YOE_100      = 9'd100;
  localparam logic [YOE_W-1:0]    YOE_200      = 9'd200;
  localparam logic [YOE_W-1:0]    YOE_300      = 9'd300;
  localparam logic [MT_W-1:0]     MP_DAYS      = 11'd153;
  localparam logic [MP_W-1:0]     MP_JAN       = 4'd10;
  localparam logic [MP_W-1:0]     MP_MONTH_ADD = 4'd3;
  localparam logic [MP_W-1:0]     MP_MONTH_SUB = 4'd9;
  localparam logic [YEAR_F_W-1:0] MAX_YEAR_F   = 24'd9999;
  localparam year_t               MAX_YEAR     = 14'd9999;

  // Reciprocals: floor(n / d) == (n * R) >> S over the operand range
  localparam int unsigned ERA_SHIFT = 49;
  localparam logic [63:0] ERA_RECIP_F = (64'd1 << ERA_SHIFT) / 64'd146097;
  localparam logic [31:0] ERA_RECIP   = ERA_RECIP_F[31:0];  // underestimates by <= 1

  localparam int unsigned D1460_SHIFT = 29;
  localparam logic [63:0] D1460_RECIP_F = ((64'd1 << D1460_SHIFT) + 64'd1459) / 64'd1460;
  localparam logic [18:0] D1460_RECIP   = D1460_RECIP_F[18:0];

  localparam int unsigned D365_SHIFT = 27;
  localparam logic [63:0] D365_RECIP_F = ((64'd1 << D365_SHIFT) + 64'd364) / 64'd365;
  localparam logic [18:0] D365_RECIP   = D365_RECIP_F[18:0];

  localparam int unsigned D153_SHIFT = 19;
  localparam logic [63:0] D153_RECIP_F = ((64'd1 << D153_SHIFT) + 64'd152) / 64'd153;
  localparam logic [11:0] D153_RECIP   = D153_RECIP_F[11:0];

  localparam int unsigned D5_SHIFT = 14;
  localparam logic [63:0] D5_RECIP_F = ((64'd1 << D5_SHIFT) + 64'd4) / 64'd5;
  localparam logic [11:0] D5_RECIP   = D5_RECIP_F[11:0];

endpackage

FILE: rtl/core/dnd_if.sv
// ----------------------------------------------------------------------------
// dnd_if: stream channels of the day-number-to-date converter
// Valid/ready channels for day-number beats in and date beats out.
// ----------------------------------------------------------------------------
interface dnd_day_if;
  import dnd_pkg::*;

  logic     valid;
  logic     ready;
  day_num_t day_number;

  modport source (output valid, output day_number, input ready);
  modport sink   (input valid, input day_number, output ready);
endinterface

interface dnd_date_if;
  import dnd_pkg::*;

  logic   valid;
  logic   ready;
  year_t  year;
  month_t month;
  dom_t   day_of_month;
  logic   invalid;
  logic   year_clamped;

  modport source (
    output valid, output year, output month, output day_of_month,
    output invalid, output year_clamped, input ready
  );
  modport sink (
    input valid, input year, input month, input day_of_month,
    input invalid, input year_clamped, output ready
  );
endinterface

FILE: rtl/core/dnd_era_div.sv
// ----------------------------------------------------------------------------
// dnd_era_div: split day count into 400-year era and day of era
// Four stages: offset, reciprocal multiply, remainder, one-step correction.
// ----------------------------------------------------------------------------
module dnd_era_div (
  input  logic                               clk_i,
  input  logic [dnd_pkg::ERA_STAGES-1:0]     ld_i,
  input  dnd_pkg::day_num_t                  day_number_i,
  output dnd_pkg::era_t                      era_o,
  output dnd_pkg::doe_t                      doe_o,
  output logic                               invalid_o
);
  import dnd_pkg::*;

  // stage 0
  logic [Z_W-1:0]   z0_q;
  logic             inv0_q;
  // stage 1
  logic [2*Z_W-1:0] prod;
  era_t             qe1_q;
  logic [Z_W-1:0]   z1_q;
  logic             inv1_q;
  // stage 2
  logic [Z_W-1:0]   qm;
  logic [Z_W-1:0]   rem_full;
  logic [REM_W-1:0] rem2_q;
  era_t             qe2_q;
  logic             inv2_q;
  // stage 3
  logic             over;
  logic [REM_W-1:0] rem_adj;
  era_t             era3_q;
  doe_t             doe3_q;
  logic             inv3_q;

  assign prod     = z0_q * ERA_RECIP;
  assign qm       = qe1_q * ERA_DAYS;
  assign rem_full = z1_q - qm;
  assign over     = (rem2_q >= {1'b0, ERA_DAYS});
  assign rem_adj  = rem2_q - {1'b0, ERA_DAYS};

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      z0_q   <= day_number_i + MARCH_OFFSET;
      inv0_q <= (day_number_i == '0) | day_number_i[DAY_NUM_W-1];
    end
    if (ld_i[1]) begin
      qe1_q  <= prod[2*Z_W-1:ERA_SHIFT];
      z1_q   <= z0_q;
      inv1_q <= inv0_q;
    end
    if (ld_i[2]) begin
      rem2_q <= rem_full[REM_W-1:0];
      qe2_q  <= qe1_q;
      inv2_q <= inv1_q;
    end
    if (ld_i[3]) begin
      era3_q <= qe2_q + ERA_W'(over);
      doe3_q <= over ? rem_adj[DOE_W-1:0] : rem2_q[DOE_W-1:0];
      inv3_q <= inv2_q;
    end
  end

  assign era_o     = era3_q;
  assign doe_o     = doe3_q;
  assign invalid_o = inv3_q;

endmodule

FILE: rtl/core/day_number_to_date.sv
// ----------------------------------------------------------------------------
// day_number_to_date: signed day number (0001-01-01 = 1) to Gregorian date
// An accepted input beat passes through every stage in order to its output beat.
// Throughput: one beat per cycle when not stalled; every stage holds its beat under
// back-pressure and an empty stage downstream lets the stages above it keep loading.
// Reset clears the stage valid bits only; no calendar state is kept.
// ----------------------------------------------------------------------------
module day_number_to_date (
  input  logic       clk_i,
  input  logic       rst_ni,
  dnd_day_if.sink    day_i,
  dnd_date_if.source date_o
);
  import dnd_pkg::*;

  // Stage valid bits and per-stage load enables. A stage may load when any
  // stage at or below it is empty, or when the output beat is being taken.
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] ld;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ld
    assign ld[k] = date_o.ready | ~(&v_q[NUM_STAGES-1:k]);
  end

  assign day_i.ready = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (ld[k]) begin
          v_q[k] <= (k == 0) ? day_i.valid : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // Stages 0..3: era and day of era
  era_t era3;
  doe_t doe3;
  logic inv3;

  dnd_era_div u_era_div (
    .clk_i        (clk_i),
    .ld_i         (ld[ERA_STAGES-1:0]),
    .day_number_i (day_i.day_number),
    .era_o        (era3),
    .doe_o        (doe3),
    .invalid_o    (inv3)
  );

  // Stage 4: the three leap corrections of doe
  logic [DOE_W+19-1:0] p1460;
  logic [6:0]          a4_q;
  logic [2:0]          b4_q;
  logic                c4_q;
  doe_t                doe4_q;
  era_t                era4_q;
  logic                inv4_q;
  logic [2:0]          cent_cnt;

  assign p1460    = doe3 * D1460_RECIP;
  assign cent_cnt = 3'(doe3 >= CENT_DAYS_1) + 3'(doe3 >= CENT_DAYS_2)
                  + 3'(doe3 >= CENT_DAYS_3) + 3'(doe3 >= ERA_LAST_DAY);

  // Stage 5: corrected day count inside the era
  doe_t n5_q;
  doe_t doe5_q;
  era_t era5_q;
  logic inv5_q;
  doe_t n_sum;

  assign n_sum = doe4_q - DOE_W'(a4_q) + DOE_W'(b4_q) - DOE_W'(c4_q);

  // Stage 6: year of era = n / 365
  logic [DOE_W+19-1:0] p365;
  logic [YOE_W-1:0]    yoe6_q;
  doe_t                doe6_q;
  era_t                era6_q;
  logic                inv6_q;

  assign p365 = n5_q * D365_RECIP;

  // Stage 7: day of year and year before the January/February bump
  logic [DOE_W-1:0]    yoe_days;
  logic [DOE_W-1:0]    yr_start;
  logic [1:0]          cent_yrs;
  logic [DOE_W-1:0]    doy_full;
  logic [YEAR_F_W-1:0] era_yrs;
  logic [YEAR_F_W-1:0] year_sum;
  logic [DOY_W-1:0]    doy7_q;
  logic [YEAR_F_W-1:0] year7_q;
  logic                inv7_q;

  assign yoe_days = yoe6_q * YEAR_DAYS;
  assign cent_yrs = 2'(yoe6_q >= YOE_100) + 2'(yoe6_q >= YOE_200) + 2'(yoe6_q >= YOE_300);
  assign yr_start = yoe_days + DOE_W'(yoe6_q >> 2) - DOE_W'(cent_yrs);
  assign doy_full = doe6_q - yr_start;
  assign era_yrs  = era6_q * ERA_YEARS;
  assign year_sum = era_yrs + YEAR_F_W'(yoe6_q);

  // Stage 8: March-based month = (5*doy + 2) / 153
  logic [MT_W-1:0]    t8;
  logic [MT_W+12-1:0] p153;
  logic [MP_W-1:0]    mp8_q;
  logic [DOY_W-1:0]   doy8_q;
  logic [YEAR_F_W-1:0] year8_q;
  logic               inv8_q;

  assign t8   = (MT_W'(doy7_q) << 2) + MT_W'(doy7_q) + MT_W'(2);
  assign p153 = t8 * D153_RECIP;

  // Stage 9: day of month, calendar month, final year
  // (153*mp + 2) / 5 reaches 337, so the quotient takes DOY_W bits
  logic [MT_W-1:0]     u9;
  logic [MT_W+12-1:0]  p5;
  logic [DOY_W-1:0]    dom_full;
  logic                jan_feb;
  dom_t                dom9_q;
  month_t              mon9_q;
  logic [YEAR_F_W-1:0] year9_q;
  logic                inv9_q;

  assign u9       = MT_W'(mp8_q) * MP_DAYS + MT_W'(2);
  assign p5       = u9 * D5_RECIP;
  assign dom_full = doy8_q - p5[D5_SHIFT+DOY_W-1:D5_SHIFT] + DOY_W'(1);
  assign jan_feb  = (mp8_q >= MP_JAN);

  // Stage 10: clamp and invalid masking, output register
  year_t  year_q;
  month_t month_q;
  dom_t   dom_q;
  logic   invalid_q;
  logic   clamped_q;
  logic   over_max;

  assign over_max = (year9_q > MAX_YEAR_F);

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      a4_q   <= p1460[D1460_SHIFT+6:D1460_SHIFT];
      b4_q   <= cent_cnt;
      c4_q   <= (doe3 == ERA_LAST_DAY);
      doe4_q <= doe3;
      era4_q <= era3;
      inv4_q <= inv3;
    end
    if (ld[5]) begin
      n5_q   <= n_sum;
      doe5_q <= doe4_q;
      era5_q <= era4_q;
      inv5_q <= inv4_q;
    end
    if (ld[6]) begin
      yoe6_q <= p365[D365_SHIFT+YOE_W-1:D365_SHIFT];
      doe6_q <= doe5_q;
      era6_q <= era5_q;
      inv6_q <= inv5_q;
    end
    if (ld[7]) begin
      doy7_q  <= doy_full[DOY_W-1:0];
      year7_q <= year_sum;
      inv7_q  <= inv6_q;
    end
    if (ld[8]) begin
      mp8_q   <= p153[D153_SHIFT+MP_W-1:D153_SHIFT];
      doy8_q  <= doy7_q;
      year8_q <= year7_q;
      inv8_q  <= inv7_q;
    end
    if (ld[9]) begin
      dom9_q  <= dom_full[DOM_W-1:0];
      mon9_q  <= jan_feb ? (mp8_q - MP_MONTH_SUB) : (mp8_q + MP_MONTH_ADD);
      year9_q <= year8_q + YEAR_F_W'(jan_feb);
      inv9_q  <= inv8_q;
    end
    if (ld[10]) begin
      // invalid beats leave every date field at zero
      if (inv9_q) begin
        year_q    <= '0;
        month_q   <= '0;
        dom_q     <= '0;
        invalid_q <= 1'b1;
        clamped_q <= 1'b0;
      end else begin
        year_q    <= over_max ? MAX_YEAR : year9_q[YEAR_W-1:0];
        month_q   <= mon9_q;
        dom_q     <= dom9_q;
        invalid_q <= 1'b0;
        clamped_q <= over_max;
      end
    end
  end

  assign date_o.valid        = v_q[NUM_STAGES-1];
  assign date_o.year         = year_q;
  assign date_o.month        = month_q;
  assign date_o.day_of_month = dom_q;
  assign date_o.invalid      = invalid_q;
  assign date_o.year_clamped = clamped_q;

endmodule

FILE: rtl/core/dnd_checker.sv
// ----------------------------------------------------------------------------
// dnd_checker: port-level checks for the day-number-to-date converter
// Checks field consistency of date beats and hold under back-pressure.
// ----------------------------------------------------------------------------
module dnd_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            valid_i,
  input logic            ready_i,
  input dnd_pkg::year_t  year_i,
  input dnd_pkg::month_t month_i,
  input dnd_pkg::dom_t   day_of_month_i,
  input logic            invalid_i,
  input logic            year_clamped_i
);
  import dnd_pkg::*;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && invalid_i |->
      year_i == '0 && month_i == '0 && day_of_month_i == '0 && !year_clamped_i)
    else $error("invalid beat carries nonzero date fields");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !invalid_i |->
      month_i >= 4'd1 && month_i <= 4'd12 && day_of_month_i >= 5'd1 &&
      year_i >= 14'd1 && year_i <= MAX_YEAR)
    else $error("valid date beat out of calendar range");

  a_clamp_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && year_clamped_i |-> year_i == MAX_YEAR && !invalid_i)
    else $error("clamped beat without maximum year");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=>
      valid_i && $stable(year_i) && $stable(month_i) &&
      $stable(day_of_month_i) && $stable(invalid_i) && $stable(year_clamped_i))
    else $error("stalled date beat changed");

endmodule

bind day_number_to_date dnd_checker u_dnd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (date_o.valid),
  .ready_i        (date_o.ready),
  .year_i         (date_o.year),
  .month_i        (date_o.month),
  .day_of_month_i (date_o.day_of_month),
  .invalid_i      (date_o.invalid),
  .year_clamped_i (date_o.year_clamped)
);
